// ===== design/srms_pkg.sv =====
package srms_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int SQ_W         = 31;
  localparam int LEVEL_W      = 16;
  localparam int LANES        = 2;
  localparam int ROOT_W       = 16;
  localparam int RAD_W        = 2 * ROOT_W;
  localparam int MAX_FRAMES_DEF = 1024;

  localparam logic [LEVEL_W-1:0] KEEP_RESET = 16'd60948;
  localparam logic [LEVEL_W-1:0] CEIL_RESET = 16'd11141;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEEP = 1'b0,
    CFG_CEIL = 1'b1
  } cfg_reg_e;

endpackage

// ===== design/srms_lane.sv =====
module srms_lane
  import srms_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic        [SQ_W-1:0]     sq_o
);

  logic signed [2*SAMPLE_W-1:0] prod;
  logic        [SQ_W-1:0]       sq_q;

  assign prod = sample_i * sample_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sq_q <= prod[SQ_W-1:0];
    end
  end

  assign sq_o = sq_q;

endmodule

// ===== design/srms_div.sv =====
module srms_div
  import srms_pkg::*;
#(
  parameter int DIV_W = 42,
  parameter int DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  diff;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    if (start_i) begin
      cnt_d = STEP_W'(DIV_W);
      rem_d = '0;
      dvs_d = divisor_i;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!diff[DVS_W+1]) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DVS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule

// ===== design/srms_sqrt.sv =====
module srms_sqrt
  import srms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int STEP_W = $clog2(ROOT_W + 1);

  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;

  // two radicand bits per cycle
  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_comb begin
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      cnt_d  = STEP_W'(ROOT_W);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = (ROOT_W+1)'(rem_sh - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[ROOT_W:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

endmodule

// ===== design/stereo_rms_level_meter.sv =====
// channel     dir  handshake                      payload
// s_axis      in   s_axis_tvalid / s_axis_tready  tdata: left, right; tlast: last of buffer
// m_axis      out  m_axis_tvalid / m_axis_tready  tdata: rms, smoothed, scaled
// cfg         in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// a frame that does not close a buffer passes through the lane squares, then the merge add
// a closing frame then goes through the shared divider for the mean, the root unit,
// the smoothing multiplies and the divider again for the scaled level
// rst_ni clears the accumulator, count, smoothed level and config to their defaults
// the output register lets the next frame in while a result waits on m_axis_tready
module stereo_rms_level_meter
  import srms_pkg::*;
#(
  parameter int MAX_BUFFER_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // [15:0] rms, [31:16] smoothed, [47:32] scaled
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEVEL_W-1:0]   cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_BUFFER_FRAMES + 1);
  localparam int SUM_W = 32 + $clog2(MAX_BUFFER_FRAMES);
  localparam int DIV_W = (SUM_W > 32) ? SUM_W : 32;
  localparam int DVS_W = (CNT_W + 1 > LEVEL_W) ? CNT_W + 1 : LEVEL_W;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MERGE   = 8'b0000_0010,
    ST_MEAN    = 8'b0000_0100,
    ST_ROOT    = 8'b0000_1000,
    ST_MUL_OLD = 8'b0001_0000,
    ST_MUL_NEW = 8'b0010_0000,
    ST_BLEND   = 8'b0100_0000,
    ST_SCALE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [LEVEL_W-1:0] keep_q, ceil_q;
  logic [SUM_W-1:0]   sum_q, sum_d, sum_nx;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_nx;
  logic [LEVEL_W-1:0] avg_q, avg_d;
  logic               last_q;
  logic [ROOT_W-1:0]  rms_q;
  logic [31:0]        acc_q, prod_q;
  logic               out_valid_q, out_valid_d;
  logic [47:0]        out_data_q;

  logic                       accept, close_buf, out_load;
  logic signed [SAMPLE_W-1:0] sample [LANES];
  logic [SQ_W-1:0]            sq [LANES];

  logic             div_start, div_busy;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0] div_divisor;
  logic             root_start, root_busy;
  logic [ROOT_W-1:0] root;

  logic [LEVEL_W:0]   weight;
  logic [32:0]        mul_new, blend;
  logic [31:0]        mul_old;
  logic [LEVEL_W-1:0] ceil_eff, scaled;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign sample[0] = s_axis_tdata[15:0];
  assign sample[1] = s_axis_tdata[31:16];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    srms_lane u_lane (
      .clk_i   (clk_i),
      .load_i  (accept),
      .sample_i(sample[g]),
      .sq_o    (sq[g])
    );
  end

  // merge of both lanes into the buffer sum
  assign sum_nx    = sum_q + SUM_W'(sq[0]) + SUM_W'(sq[1]);
  assign cnt_nx    = cnt_q + 1'b1;
  assign close_buf = last_q || (cnt_nx == CNT_W'(MAX_BUFFER_FRAMES));

  assign weight  = (LEVEL_W+1)'(1 << LEVEL_W) - {1'b0, keep_q};
  assign mul_old = keep_q * avg_q;
  assign mul_new = weight * rms_q;
  assign blend   = {1'b0, acc_q} + {1'b0, prod_q} + 33'(1 << (LEVEL_W - 1));

  assign ceil_eff = (ceil_q == '0) ? LEVEL_W'(1) : ceil_q;
  assign scaled   = (div_quo[DIV_W-1:LEVEL_W] != '0) ? '1 : div_quo[LEVEL_W-1:0];
  assign out_load = (state_q == ST_SCALE) && !div_busy && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    avg_d        = avg_q;
    div_start    = 1'b0;
    div_dividend = DIV_W'(sum_nx);
    div_divisor  = DVS_W'({cnt_nx, 1'b0});
    root_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (close_buf) begin
          sum_d     = '0;
          cnt_d     = '0;
          div_start = 1'b1;
          state_d   = ST_MEAN;
        end else begin
          sum_d   = sum_nx;
          cnt_d   = cnt_nx;
          state_d = ST_IDLE;
        end
      end
      ST_MEAN: begin
        if (!div_busy) begin
          root_start = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (!root_busy) state_d = ST_MUL_OLD;
      end
      ST_MUL_OLD: state_d = ST_MUL_NEW;
      ST_MUL_NEW: state_d = ST_BLEND;
      ST_BLEND: begin
        avg_d        = blend[31:16];
        div_start    = 1'b1;
        div_dividend = DIV_W'({blend[31:16], 16'h0000});
        div_divisor  = DVS_W'(ceil_eff);
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= KEEP_RESET;
      ceil_q      <= CEIL_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_KEEP: keep_q <= cfg_data_i;
          CFG_CEIL: ceil_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) last_q <= s_axis_tlast;
    if (state_q == ST_ROOT && !root_busy) rms_q <= root;
    if (state_q == ST_MUL_OLD) acc_q <= mul_old;
    if (state_q == ST_MUL_NEW) prod_q <= mul_new[31:0];
    if (out_load) out_data_q <= {scaled, avg_q, rms_q};
  end

  srms_div #(
    .DIV_W(DIV_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quotient_o(div_quo)
  );

  srms_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_start),
    .radicand_i(div_quo[RAD_W-1:0]),
    .busy_o    (root_busy),
    .root_o    (root)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_ready_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy && !root_busy)
    else $error("input ready while a unit is busy");

  a_accept_merges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MERGE)
    else $error("accepted request not merged");

  a_count_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(MAX_BUFFER_FRAMES))
    else $error("frame count reached limit");

  a_result_from_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_SCALE))
    else $error("result without scale step");

endmodule
